// File: rtl/tgadec_pkg.sv
// ----------------------------------------------------------------------------
// tgadec_pkg
// Shared types and constants of the TGA true-color RLE decoder: result codes,
// header byte offsets and field codes, the result queue entry.
// ----------------------------------------------------------------------------
package tgadec_pkg;

  localparam int unsigned MAX_DIM_DEF    = 4096;
  localparam int unsigned MAX_PIXELS_DEF = 4194304;

  // result codes
  typedef enum logic [1:0] {
    KIND_RUN      = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_REJECT   = 2'd2,
    KIND_COMPLETE = 2'd3
  } kind_e;

  localparam logic CAUSE_HEADER    = 1'b0;
  localparam logic CAUSE_RAW_SHORT = 1'b1;

  // header byte offsets
  localparam logic [4:0] HDR_ID_LEN     = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE   = 5'd2;
  localparam logic [4:0] HDR_CMAP_FIRST = 5'd3;
  localparam logic [4:0] HDR_CMAP_LAST  = 5'd7;
  localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HDR_BPP        = 5'd16;
  localparam logic [4:0] HDR_DESC       = 5'd17;

  localparam logic [7:0] TYPE_RAW     = 8'd2;
  localparam logic [7:0] TYPE_RLE     = 8'd10;
  localparam logic [7:0] BPP_24       = 8'd24;
  localparam logic [7:0] BPP_32       = 8'd32;
  localparam logic [7:0] DESC_RSVD    = 8'hC0;
  localparam int unsigned DESC_TOPDOWN_BIT = 5;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // result queue
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    kind_e       kind;
    logic [31:0] color;
    logic [21:0] start;
    logic [22:0] count;
    logic [12:0] width;
    logic [12:0] height;
    logic        bottom_up;
    logic        cause;
    logic        last;
  } result_t;

endpackage

// File: rtl/tga_truecolor_rle_decoder.sv
// ----------------------------------------------------------------------------
// tga_truecolor_rle_decoder
// Streaming decoder for TGA images of type 2 (raw) and 10 (RLE) at 24 or
// 32 bpp. Checks the header, skips the ID field and reports ARGB pixel runs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one file byte per transfer (data_byte_i, last_byte_i),
//   qualified by in_valid_i and held off by in_stall_o. last_byte_i marks
//   the final byte of a file; the next byte starts a new header.
//   Output channel: one result per transfer (pixel run, header accepted,
//   rejected, image complete), out_valid_o held off by out_stall_i.
//   run_last_o marks the last result caused by one input byte.
//   Throughput: one byte per cycle. A byte yields zero to three results; the
//   four-entry result queue drains one per cycle while out_stall_i is low, so
//   in_stall_o rises only while more than one result is waiting (end of
//   image, end of file, or a stalled receiver).
//   A result is queued when its byte is taken and shown at the head of the
//   queue. The header multiply is registered at the bits-per-pixel byte.
//   Reset: the decoder waits for byte 0 of a header and the queue is empty.
//   A stalled receiver keeps the head result unchanged; once the queue holds
//   two or more results, in_stall_o holds off further bytes.
// ----------------------------------------------------------------------------
module tga_truecolor_rle_decoder #(
  parameter int unsigned MAX_DIM    = tgadec_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_PIXELS = tgadec_pkg::MAX_PIXELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [31:0] run_color_o,
  output logic [21:0] run_start_o,
  output logic [22:0] run_count_o,
  output logic [12:0] image_width_o,
  output logic [12:0] image_height_o,
  output logic        bottom_up_o,
  output logic        reject_cause_o,
  output logic        run_last_o
);

  localparam int unsigned PW_RAW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PW     = (PW_RAW > 8) ? PW_RAW : 8;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ID,
    PH_PIXELS,
    PH_DONE
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [4:0]     hdr_idx_q, hdr_idx_d;
  logic [7:0]     id_left_q, id_left_d;
  logic           is_rle_q, is_rle_d;
  logic           has_alpha_q, has_alpha_d;
  logic [15:0]    width_q, width_d;
  logic [15:0]    height_q, height_d;
  logic           hdr_bad_q, hdr_bad_d;
  logic           prod_big_q, prod_big_d;
  logic [PW-1:0]  done_q, done_d;
  logic [PW-1:0]  total_q, total_d;
  logic [23:0]    color_q, color_d;
  logic [1:0]     bip_q, bip_d;
  logic [7:0]     pkt_left_q, pkt_left_d;
  logic           pkt_rep_q, pkt_rep_d;

  tgadec_pkg::result_t                    q_mem [tgadec_pkg::Q_DEPTH];
  logic [tgadec_pkg::Q_AW-1:0]            wp_q, rp_q;
  logic [tgadec_pkg::Q_CW-1:0]            cnt_q, cnt_d;

  tgadec_pkg::result_t                    res [tgadec_pkg::MAX_RES];
  tgadec_pkg::result_t                    r;
  logic [1:0]     nres;
  logic           in_fire, out_fire;
  logic [31:0]    prod;
  logic           bad_all;
  logic [PW-1:0]  rem, run_w, cnt_px, done_n;
  logic [7:0]     run8;
  logic [23:0]    col;
  logic [7:0]     alpha;
  logic [1:0]     bip_last;

  assign in_stall_o = (cnt_q > tgadec_pkg::Q_CW'(tgadec_pkg::Q_DEPTH - tgadec_pkg::MAX_RES));
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_fire   = out_valid_o & ~out_stall_i;
  assign prod       = width_q * height_q;

  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    id_left_d   = id_left_q;
    is_rle_d    = is_rle_q;
    has_alpha_d = has_alpha_q;
    width_d     = width_q;
    height_d    = height_q;
    hdr_bad_d   = hdr_bad_q;
    prod_big_d  = prod_big_q;
    done_d      = done_q;
    total_d     = total_q;
    color_d     = color_q;
    bip_d       = bip_q;
    pkt_left_d  = pkt_left_q;
    pkt_rep_d   = pkt_rep_q;
    nres        = 2'd0;
    for (int k = 0; k < tgadec_pkg::MAX_RES; k++) begin
      res[k] = '0;
    end
    r        = '0;
    bad_all  = 1'b0;
    rem      = total_q - done_q;
    run8     = {1'b0, data_byte_i[6:0]} + 8'd1;
    run_w    = PW'(run8);
    cnt_px   = '0;
    done_n   = done_q;
    col      = color_q;
    alpha    = has_alpha_q ? data_byte_i : tgadec_pkg::ALPHA_OPAQUE;
    bip_last = has_alpha_q ? 2'd3 : 2'd2;

    if (in_fire) begin
      case (phase_q)
        PH_HEADER: begin
          hdr_idx_d = hdr_idx_q + 5'd1;
          case (hdr_idx_q) inside
            tgadec_pkg::HDR_ID_LEN: begin
              id_left_d   = data_byte_i;
              hdr_bad_d   = 1'b0;
              is_rle_d    = 1'b0;
              has_alpha_d = 1'b0;
            end
            tgadec_pkg::HDR_CMAP_TYPE: begin
              if (data_byte_i != 8'd0) hdr_bad_d = 1'b1;
            end
            tgadec_pkg::HDR_IMG_TYPE: begin
              if (data_byte_i == tgadec_pkg::TYPE_RLE) is_rle_d = 1'b1;
              else if (data_byte_i != tgadec_pkg::TYPE_RAW) hdr_bad_d = 1'b1;
            end
            [tgadec_pkg::HDR_CMAP_FIRST:tgadec_pkg::HDR_CMAP_LAST]: begin
              if (data_byte_i != 8'd0) hdr_bad_d = 1'b1;
            end
            tgadec_pkg::HDR_WIDTH_LO:  width_d[7:0]   = data_byte_i;
            tgadec_pkg::HDR_WIDTH_HI:  width_d[15:8]  = data_byte_i;
            tgadec_pkg::HDR_HEIGHT_LO: height_d[7:0]  = data_byte_i;
            tgadec_pkg::HDR_HEIGHT_HI: height_d[15:8] = data_byte_i;
            tgadec_pkg::HDR_BPP: begin
              if (data_byte_i == tgadec_pkg::BPP_32) has_alpha_d = 1'b1;
              else if (data_byte_i != tgadec_pkg::BPP_24) hdr_bad_d = 1'b1;
              prod_big_d = (prod > 32'(MAX_PIXELS));
              total_d    = PW'(prod);
            end
            default: ;
          endcase
          if (hdr_idx_q == tgadec_pkg::HDR_DESC) begin
            bad_all = hdr_bad_q | ((data_byte_i & tgadec_pkg::DESC_RSVD) != 8'd0) |
                      (width_q == 16'd0) | (height_q == 16'd0) |
                      (width_q > 16'(MAX_DIM)) | (height_q > 16'(MAX_DIM)) | prod_big_q;
            if (bad_all || last_byte_i) begin
              r.kind  = tgadec_pkg::KIND_REJECT;
              r.cause = tgadec_pkg::CAUSE_HEADER;
              res[0]  = r;
              nres    = 2'd1;
              phase_d = PH_DONE;
            end else begin
              r.kind      = tgadec_pkg::KIND_ACCEPT;
              r.width     = width_q[12:0];
              r.height    = height_q[12:0];
              r.bottom_up = ~data_byte_i[tgadec_pkg::DESC_TOPDOWN_BIT];
              res[0]      = r;
              nres        = 2'd1;
              phase_d     = (id_left_q != 8'd0) ? PH_ID : PH_PIXELS;
              done_d      = '0;
              color_d     = '0;
              bip_d       = 2'd0;
              pkt_left_d  = 8'd0;
              pkt_rep_d   = 1'b0;
            end
          end else if (last_byte_i) begin
            r.kind  = tgadec_pkg::KIND_REJECT;
            r.cause = tgadec_pkg::CAUSE_HEADER;
            res[0]  = r;
            nres    = 2'd1;
          end
        end
        PH_ID: begin
          id_left_d = id_left_q - 8'd1;
          if (id_left_d == 8'd0) phase_d = PH_PIXELS;
          if (last_byte_i) begin
            r.kind  = tgadec_pkg::KIND_REJECT;
            r.cause = tgadec_pkg::CAUSE_HEADER;
            res[0]  = r;
            nres    = 2'd1;
          end
        end
        PH_PIXELS: begin
          if (is_rle_q && (pkt_left_q == 8'd0)) begin
            pkt_left_d = (run_w > rem) ? rem[7:0] : run8;
            pkt_rep_d  = data_byte_i[7];
            bip_d      = 2'd0;
            color_d    = '0;
          end else begin
            case (bip_q)
              2'd0:    col[7:0]   = data_byte_i;
              2'd1:    col[15:8]  = data_byte_i;
              2'd2:    col[23:16] = data_byte_i;
              default: ;
            endcase
            if (bip_q == bip_last) begin
              cnt_px  = (is_rle_q && pkt_rep_q) ? PW'(pkt_left_q) : PW'(1);
              done_n  = done_q + cnt_px;
              r.kind  = tgadec_pkg::KIND_RUN;
              r.color = {alpha, col};
              r.start = 22'(done_q);
              r.count = 23'(cnt_px);
              res[0]  = r;
              nres    = 2'd1;
              done_d  = done_n;
              if (is_rle_q) pkt_left_d = pkt_left_q - cnt_px[7:0];
              bip_d   = 2'd0;
              color_d = '0;
            end else begin
              bip_d   = bip_q + 2'd1;
              color_d = col;
            end
          end
          if (done_n >= total_q) begin
            r         = '0;
            r.kind    = tgadec_pkg::KIND_COMPLETE;
            res[nres] = r;
            nres      = nres + 2'd1;
            phase_d   = PH_DONE;
          end else if (last_byte_i) begin
            if (is_rle_q) begin
              r         = '0;
              r.kind    = tgadec_pkg::KIND_RUN;
              r.start   = 22'(done_n);
              r.count   = 23'(total_q - done_n);
              res[nres] = r;
              r         = '0;
              r.kind    = tgadec_pkg::KIND_COMPLETE;
              res[nres + 2'd1] = r;
              nres      = nres + 2'd2;
              done_d    = total_q;
            end else begin
              r         = '0;
              r.kind    = tgadec_pkg::KIND_REJECT;
              r.cause   = tgadec_pkg::CAUSE_RAW_SHORT;
              res[nres] = r;
              nres      = nres + 2'd1;
            end
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
      if (last_byte_i) begin
        phase_d   = PH_HEADER;
        hdr_idx_d = 5'd0;
      end
    end
    for (int k = 0; k < tgadec_pkg::MAX_RES; k++) begin
      res[k].last = (2'(k) == nres - 2'd1);
    end
    cnt_d = cnt_q + tgadec_pkg::Q_CW'(nres) - tgadec_pkg::Q_CW'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_idx_q   <= '0;
      id_left_q   <= '0;
      is_rle_q    <= 1'b0;
      has_alpha_q <= 1'b0;
      hdr_bad_q   <= 1'b0;
      prod_big_q  <= 1'b0;
      done_q      <= '0;
      bip_q       <= '0;
      pkt_left_q  <= '0;
      pkt_rep_q   <= 1'b0;
      wp_q        <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      id_left_q   <= id_left_d;
      is_rle_q    <= is_rle_d;
      has_alpha_q <= has_alpha_d;
      hdr_bad_q   <= hdr_bad_d;
      prod_big_q  <= prod_big_d;
      done_q      <= done_d;
      bip_q       <= bip_d;
      pkt_left_q  <= pkt_left_d;
      pkt_rep_q   <= pkt_rep_d;
      wp_q        <= wp_q + tgadec_pkg::Q_AW'(nres);
      rp_q        <= rp_q + tgadec_pkg::Q_AW'(out_fire);
      cnt_q       <= cnt_d;
    end
  end

  // image geometry and pixel payload
  always_ff @(posedge clk_i) begin
    width_q  <= width_d;
    height_q <= height_d;
    total_q  <= total_d;
    color_q  <= color_d;
  end

  // result queue
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < tgadec_pkg::MAX_RES; k++) begin
      if (2'(k) < nres) begin
        q_mem[wp_q + tgadec_pkg::Q_AW'(k)] <= res[k];
      end
    end
  end

  assign result_kind_o  = q_mem[rp_q].kind;
  assign run_color_o    = q_mem[rp_q].color;
  assign run_start_o    = q_mem[rp_q].start;
  assign run_count_o    = q_mem[rp_q].count;
  assign image_width_o  = q_mem[rp_q].width;
  assign image_height_o = q_mem[rp_q].height;
  assign bottom_up_o    = q_mem[rp_q].bottom_up;
  assign reject_cause_o = q_mem[rp_q].cause;
  assign run_last_o     = q_mem[rp_q].last;

endmodule

// File: rtl/tgadec_checker.sv
// ----------------------------------------------------------------------------
// tgadec_checker
// Port-level checks of the TGA decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tgadec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  result_kind_o,
  input logic [31:0] run_color_o,
  input logic [21:0] run_start_o,
  input logic [22:0] run_count_o,
  input logic [12:0] image_width_o,
  input logic [12:0] image_height_o,
  input logic        bottom_up_o,
  input logic        reject_cause_o,
  input logic        run_last_o
);

  logic is_run;
  assign is_run = (result_kind_o == tgadec_pkg::KIND_RUN);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_kind_o) && $stable(run_color_o) &&
      $stable(run_start_o) && $stable(run_count_o) && $stable(run_last_o))
    else $error("stalled output result changed");

  // accept, reject and complete always close the results of their byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_run |-> run_last_o)
    else $error("status result not last of its byte");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_run |-> run_color_o == 32'd0 && run_start_o == 22'd0 &&
      run_count_o == 23'd0)
    else $error("status result carries run fields");

  a_run_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_run |-> image_width_o == 13'd0 && image_height_o == 13'd0 &&
      !bottom_up_o && !reject_cause_o)
    else $error("pixel run carries header fields");

endmodule

bind tga_truecolor_rle_decoder tgadec_checker u_tgadec_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TGA true-color decoder. Files are built byte by
// byte (good, faulty, cut short, noisy) and streamed in; a behavioral decoder
// predicts every result, and each output transfer is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import tgadec_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_ID, PH_PIXELS, PH_DONE} dec_phase_e;

  typedef enum int {
    F_CMAP, F_IMG_TYPE, F_CMAP_FIELD, F_BPP, F_DESC_RSVD, F_WIDTH_ZERO, F_HEIGHT_ZERO,
    F_WIDTH_BIG, F_HEIGHT_BIG, F_AREA_BIG, F_RANDOM_DIMS, F_LAST_AT_DESC, F_SHORT, F_COUNT
  } hdr_fault_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [31:0] run_color;
  logic [21:0] run_start;
  logic [22:0] run_count;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic        bottom_up;
  logic        reject_cause;
  logic        run_last;

  // decoder model state
  dec_phase_e  dec_phase;
  logic [4:0]  dec_hdr_idx;
  logic [7:0]  dec_id_left;
  logic        dec_rle;
  logic        dec_alpha;
  logic        dec_bad;
  logic        dec_topdown;
  logic [15:0] dec_width;
  logic [15:0] dec_height;
  logic [22:0] dec_done;
  logic [22:0] dec_total;
  logic [23:0] dec_color;
  logic [1:0]  dec_bip;
  logic [7:0]  dec_pkt_left;
  logic        dec_pkt_rep;

  result_t     step_results[$];
  result_t     decoded_results[$];
  logic [7:0]  file_q[$];
  int unsigned mismatches = 0;
  bit          idle_en    = 1'b0;
  int unsigned stall_hold = 0;

  tga_truecolor_rle_decoder DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_o  (result_kind),
    .run_color_o    (run_color),
    .run_start_o    (run_start),
    .run_count_o    (run_count),
    .image_width_o  (image_width),
    .image_height_o (image_height),
    .bottom_up_o    (bottom_up),
    .reject_cause_o (reject_cause),
    .run_last_o     (run_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tga_truecolor_rle_decoder verification failed");
    $finish;
  end

  function automatic int unsigned pick_idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 20);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_bpp();
    return $urandom_range(0, 1) ? BPP_32 : BPP_24;
  endfunction

  function automatic logic [7:0] pick_type();
    return $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW;
  endfunction

  function automatic logic [7:0] rand_desc();
    return {2'b00, 6'($urandom_range(0, 63))};
  endfunction

  function automatic result_t make_result(kind_e k, logic [31:0] c, logic [21:0] s,
                                          logic [22:0] n);
    result_t r;
    r = '0;
    r.kind = k;
    r.color = c;
    r.start = s;
    r.count = n;
    return r;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("kind=%0d color=%h start=%0d count=%0d w=%0d h=%0d bu=%0b cause=%0b last=%0b",
                     r.kind, r.color, r.start, r.count, r.width, r.height, r.bottom_up,
                     r.cause, r.last);
  endfunction

  task automatic reset_decoder_model();
    dec_phase = PH_HEADER;
    dec_hdr_idx = '0;
    dec_id_left = '0;
    dec_rle = 1'b0;
    dec_alpha = 1'b0;
    dec_bad = 1'b0;
    dec_topdown = 1'b0;
    dec_width = '0;
    dec_height = '0;
    dec_done = '0;
    dec_total = '0;
    dec_color = '0;
    dec_bip = '0;
    dec_pkt_left = '0;
    dec_pkt_rep = 1'b0;
  endtask

  task automatic add_reject(input logic cause);
    result_t r;
    r = make_result(KIND_REJECT, '0, '0, '0);
    r.cause = cause;
    step_results.push_back(r);
    dec_phase = PH_DONE;
  endtask

  task automatic decode_header_byte(input logic [7:0] b, input logic fin);
    result_t r;
    logic [31:0] area;
    case (dec_hdr_idx)
      HDR_ID_LEN:    dec_id_left = b;
      HDR_CMAP_TYPE: if (b != 8'd0) dec_bad = 1'b1;
      HDR_IMG_TYPE: begin
        if (b == TYPE_RLE) dec_rle = 1'b1;
        else if (b != TYPE_RAW) dec_bad = 1'b1;
      end
      HDR_WIDTH_LO:  dec_width[7:0] = b;
      HDR_WIDTH_HI:  dec_width[15:8] = b;
      HDR_HEIGHT_LO: dec_height[7:0] = b;
      HDR_HEIGHT_HI: dec_height[15:8] = b;
      HDR_BPP: begin
        if (b == BPP_32) dec_alpha = 1'b1;
        else if (b != BPP_24) dec_bad = 1'b1;
      end
      HDR_DESC: begin
        if ((b & DESC_RSVD) != 8'd0) dec_bad = 1'b1;
        dec_topdown = b[DESC_TOPDOWN_BIT];
        area = 32'(dec_width) * 32'(dec_height);
        if (dec_width == 0 || dec_height == 0 || dec_width > MAX_DIM_DEF ||
            dec_height > MAX_DIM_DEF || area > MAX_PIXELS_DEF)
          dec_bad = 1'b1;
      end
      default: begin
        if (dec_hdr_idx >= HDR_CMAP_FIRST && dec_hdr_idx <= HDR_CMAP_LAST && b != 8'd0)
          dec_bad = 1'b1;
      end
    endcase
    if (dec_hdr_idx < HDR_DESC) begin
      dec_hdr_idx = dec_hdr_idx + 5'd1;
      if (fin) add_reject(CAUSE_HEADER);
    end else if (dec_bad || fin) begin
      add_reject(CAUSE_HEADER);
    end else begin
      r = make_result(KIND_ACCEPT, '0, '0, '0);
      r.width = dec_width[12:0];
      r.height = dec_height[12:0];
      r.bottom_up = ~dec_topdown;
      step_results.push_back(r);
      dec_total = 23'(32'(dec_width) * 32'(dec_height));
      dec_phase = (dec_id_left != 8'd0) ? PH_ID : PH_PIXELS;
    end
  endtask

  task automatic decode_pixel_byte(input logic [7:0] b, input logic fin);
    int unsigned nbytes, run, rem, cnt;
    logic [7:0] alpha;
    nbytes = dec_alpha ? 4 : 3;
    if (dec_rle && dec_pkt_left == 8'd0) begin
      run = 32'(b[6:0]) + 1;
      rem = 32'(dec_total) - 32'(dec_done);
      if (run > rem) run = rem;
      dec_pkt_left = 8'(run);
      dec_pkt_rep = b[7];
      dec_bip = '0;
      dec_color = '0;
    end else begin
      if (dec_bip < 2'd3) dec_color[8*dec_bip +: 8] = b;
      if (32'(dec_bip) + 1 >= nbytes) begin
        alpha = dec_alpha ? b : ALPHA_OPAQUE;
        cnt = (dec_rle && dec_pkt_rep) ? 32'(dec_pkt_left) : 1;
        step_results.push_back(make_result(KIND_RUN, {alpha, dec_color}, dec_done[21:0],
                                           23'(cnt)));
        dec_done = dec_done + 23'(cnt);
        if (dec_rle) dec_pkt_left = dec_pkt_left - 8'(cnt);
        dec_bip = '0;
        dec_color = '0;
      end else begin
        dec_bip = dec_bip + 2'd1;
      end
    end
    if (dec_done >= dec_total) begin
      step_results.push_back(make_result(KIND_COMPLETE, '0, '0, '0));
      dec_phase = PH_DONE;
    end else if (fin) begin
      if (dec_rle) begin
        // fill the rest with transparent black
        step_results.push_back(make_result(KIND_RUN, '0, dec_done[21:0],
                                           dec_total - dec_done));
        dec_done = dec_total;
        step_results.push_back(make_result(KIND_COMPLETE, '0, '0, '0));
        dec_phase = PH_DONE;
      end else begin
        add_reject(CAUSE_RAW_SHORT);
      end
    end
  endtask

  task automatic decode_tga_byte(input logic [7:0] b, input logic fin);
    step_results = {};
    case (dec_phase)
      PH_HEADER: decode_header_byte(b, fin);
      PH_ID: begin
        dec_id_left = dec_id_left - 8'd1;
        if (dec_id_left == 8'd0) dec_phase = PH_PIXELS;
        if (fin) add_reject(CAUSE_HEADER);
      end
      PH_PIXELS: decode_pixel_byte(b, fin);
      default: ;
    endcase
    if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) decoded_results.push_back(step_results[i]);
    if (fin) reset_decoder_model();
  endtask

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected %s", fmt_result(want));
      $display("  actual   %s", fmt_result(got));
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) decode_tga_byte(data_byte, last_byte);
      if (out_valid && !out_stall) begin
        got.kind = kind_e'(result_kind);
        got.color = run_color;
        got.start = run_start;
        got.count = run_count;
        got.width = image_width;
        got.height = image_height;
        got.bottom_up = bottom_up;
        got.cause = reject_cause;
        got.last = run_last;
        if (decoded_results.size() == 0) begin
          note_mismatch("result with nothing expected", '0, got);
        end else begin
          want = decoded_results.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_hold = pick_idle_len();
    end else begin
      out_stall <= 1'b0;
      stall_hold = $urandom_range(0, 4);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? pick_idle_len() + 1 : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file(input int pause_at);
    for (int i = 0; i < file_q.size(); i++) begin
      if (i == pause_at) wait_for_drain();
      send_byte(file_q[i], i == file_q.size() - 1);
    end
    file_q = {};
  endtask

  task automatic add_header(input logic [7:0] id_len, input logic [7:0] itype,
                            input logic [7:0] bpp, input logic [7:0] desc,
                            input logic [15:0] w, input logic [15:0] h);
    file_q.push_back(id_len);
    file_q.push_back(8'd0);
    file_q.push_back(itype);
    repeat (5) file_q.push_back(8'd0);
    repeat (4) file_q.push_back(rand_byte());
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(h[15:8]);
    file_q.push_back(bpp);
    file_q.push_back(desc);
  endtask

  task automatic set_dims(input logic [15:0] w, input logic [15:0] h);
    file_q[HDR_WIDTH_LO] = w[7:0];
    file_q[HDR_WIDTH_HI] = w[15:8];
    file_q[HDR_HEIGHT_LO] = h[7:0];
    file_q[HDR_HEIGHT_HI] = h[15:8];
  endtask

  task automatic add_pixel(input logic [7:0] bpp);
    repeat ((bpp == BPP_32) ? 4 : 3) file_q.push_back(rand_byte());
  endtask

  task automatic add_image_data(input logic rle, input int unsigned npix,
                                input logic [7:0] bpp, input int unsigned over_pct,
                                input int unsigned rep_pct);
    int unsigned left, len, take;
    logic rep;
    if (!rle) begin
      repeat (npix) add_pixel(bpp);
    end else begin
      left = npix;
      while (left != 0) begin
        if ($urandom_range(0, 99) < over_pct) len = $urandom_range(1, 128);
        else len = $urandom_range(1, (left < 128) ? left : 128);
        rep = ($urandom_range(0, 99) < rep_pct);
        take = (len < left) ? len : left;
        file_q.push_back({rep, 7'(len - 1)});
        if (rep) add_pixel(bpp);
        else repeat (take) add_pixel(bpp);
        left -= take;
      end
    end
  endtask

  task automatic add_trailing();
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) file_q.push_back(rand_byte());
  endtask

  task automatic test_minimal_raw();
    idle_en = 1'b0;
    add_header(8'd0, TYPE_RAW, BPP_32, 8'h20, 16'd1, 16'd1);
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    send_file(-1);
  endtask

  task automatic test_header_faults();
    logic [15:0] w, h;
    logic [7:0] t;
    int f;
    idle_en = 1'b1;
    repeat (4) begin
      f = $urandom_range(0, F_COUNT - 1);
      w = 16'($urandom_range(1, 4));
      h = 16'($urandom_range(1, 4));
      add_header(8'd0, pick_type(), pick_bpp(), rand_desc(), w, h);
      case (hdr_fault_e'(f))
        F_CMAP: file_q[HDR_CMAP_TYPE] = 8'($urandom_range(1, 255));
        F_IMG_TYPE: begin
          do t = rand_byte(); while (t == TYPE_RAW || t == TYPE_RLE);
          file_q[HDR_IMG_TYPE] = t;
        end
        F_CMAP_FIELD:
          file_q[$urandom_range(HDR_CMAP_FIRST, HDR_CMAP_LAST)] = 8'($urandom_range(1, 255));
        F_BPP: begin
          do t = rand_byte(); while (t == BPP_24 || t == BPP_32);
          file_q[HDR_BPP] = t;
        end
        F_DESC_RSVD: file_q[HDR_DESC] = file_q[HDR_DESC] | (8'h40 << $urandom_range(0, 1));
        F_WIDTH_ZERO: set_dims(16'd0, h);
        F_HEIGHT_ZERO: set_dims(w, 16'd0);
        F_WIDTH_BIG: set_dims($urandom_range(0, 1) ? 16'd4097 : 16'hFFFF, h);
        F_HEIGHT_BIG: set_dims(w, $urandom_range(0, 1) ? 16'd4097 : 16'hFFFF);
        F_AREA_BIG: begin
          if ($urandom_range(0, 1)) set_dims(16'd4096, 16'd1025);
          else set_dims(16'd2049, 16'd2049);
        end
        F_RANDOM_DIMS: set_dims(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        F_SHORT: file_q = file_q[0 : $urandom_range(0, 16)];
        default: ;
      endcase
      if (f != F_LAST_AT_DESC && f != F_SHORT) add_trailing();
      send_file(-1);
    end
  endtask

  task automatic test_id_field();
    logic [7:0] id_len, bpp;
    logic rle;
    idle_en = 1'b1;
    for (int k = 0; k < 2; k++) begin
      id_len = 8'($urandom_range(1, 4));
      bpp = pick_bpp();
      rle = $urandom_range(0, 1);
      add_header(id_len, rle ? TYPE_RLE : TYPE_RAW, bpp, rand_desc(), 16'd2, 16'd1);
      repeat (id_len) file_q.push_back(rand_byte());
      add_image_data(rle, 2, bpp, 10, 50);
      // end of file inside the ID field
      if (k == 0) file_q = file_q[0 : 18 + $urandom_range(0, id_len - 1)];
      send_file(-1);
    end
  endtask

  task automatic test_raw_images();
    logic [15:0] w, h;
    logic [7:0] bpp;
    idle_en = 1'b1;
    w = 16'($urandom_range(1, 4));
    h = 16'($urandom_range(1, 3));
    bpp = pick_bpp();
    add_header(8'd0, TYPE_RAW, bpp, rand_desc(), w, h);
    add_image_data(1'b0, w * h, bpp, 0, 0);
    add_trailing();
    send_file(-1);
  endtask

  task automatic test_rle_images();
    logic [15:0] w, h;
    logic [7:0] bpp;
    for (int k = 0; k < 3; k++) begin
      idle_en = (k >= 1);
      bpp = pick_bpp();
      if (k == 2) begin
        // long repeat packets
        w = 16'($urandom_range(129, 300));
        h = 16'd1;
        add_header(8'd0, TYPE_RLE, bpp, rand_desc(), w, h);
        add_image_data(1'b1, w * h, bpp, 0, 100);
      end else begin
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 2));
        add_header(8'd0, TYPE_RLE, bpp, rand_desc(), w, h);
        add_image_data(1'b1, w * h, bpp, 15, 50);
      end
      add_trailing();
      send_file(-1);
    end
  endtask

  task automatic test_truncation();
    logic [15:0] w, h;
    logic [7:0] bpp;
    logic rle;
    idle_en = 1'b1;
    for (int k = 0; k < 2; k++) begin
      rle = k[0];
      w = 16'($urandom_range(1, 4));
      h = 16'($urandom_range(1, 2));
      bpp = pick_bpp();
      add_header(8'd0, rle ? TYPE_RLE : TYPE_RAW, bpp, rand_desc(), w, h);
      add_image_data(rle, w * h, bpp, 10, 50);
      file_q = file_q[0 : $urandom_range(18, file_q.size() - 2)];
      send_file(-1);
    end
    // largest image, cut right after the first control byte
    add_header(8'd0, TYPE_RLE, BPP_24, 8'h20, 16'd4096, 16'd1024);
    file_q.push_back(8'hFF);
    send_file(-1);
    // tallest raw image, one pixel then end of file
    add_header(8'd0, TYPE_RAW, BPP_32, 8'h00, 16'd1024, 16'd4096);
    add_pixel(BPP_32);
    send_file(-1);
  endtask

  task automatic test_noise();
    idle_en = 1'b1;
    repeat ($urandom_range(1, 24)) file_q.push_back(rand_byte());
    send_file(-1);
  endtask

  task automatic test_drain_pause();
    idle_en = 1'b1;
    add_header(8'd0, TYPE_RAW, BPP_24, rand_desc(), 16'd2, 16'd2);
    add_image_data(1'b0, 4, BPP_24, 0, 0);
    send_file(20);
  endtask

  initial begin
    reset_decoder_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_minimal_raw();
    test_header_faults();
    test_id_field();
    test_raw_images();
    test_rle_images();
    test_truncation();
    test_noise();
    test_drain_pause();
    in_valid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && decoded_results.size() == 0) begin
      $display("tga_truecolor_rle_decoder verification clean");
    end else begin
      $display("tga_truecolor_rle_decoder verification failed");
    end
    $finish;
  end

endmodule
